// File: hdl/pcd_pkg.sv
// Package for the 2x2 palette colour dilation block.
// Holds register indexes, fixed field widths and the pipeline record type.
// No dependencies.
package pcd_pkg;

  localparam int unsigned PIX_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;
  localparam int unsigned IW_W      = 9;
  localparam int unsigned IH_W      = 13;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned RESET_SIZE = 208;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_COLOUR  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             horiz;
    logic             row_pos;
    logic             last_col;
    logic             last_frame;
  } stage_t;

endpackage

// File: hdl/pixel_colour_dilate_2x2.sv
// Top level of the streaming 2x2 palette colour dilation block.
// Depends on pcd_pkg and pcd_ram.
//
// Usage:
//   Pixels of a frame enter in raster order on the in_ channel (valid/ready),
//   one 4-bit palette index per transaction. Each pixel leaves on the out_
//   channel as one transaction: the pixel in the line colour if it, its left,
//   upper or upper-left neighbour held the line colour, else unchanged, with
//   row_end and frame_end flags.
//   A pixel passes stage 1, then the output register; throughput is one pixel
//   per clock while out_ready is high. The rate is set by the one-bit line
//   store, read and written once per pixel at the pixel's column.
//   cfg_ writes set line colour (0), image width (1) and image height (2);
//   write only while no pixel is in flight.
//   After reset the line store is cleared, one column per cycle, over all
//   MAX_WIDTH columns; in_ready stays low during that pass.
//   When the receiver holds out_ready low, the output register and the one
//   stage behind it fill, then in_ready drops; nothing is lost.
module pixel_colour_dilate_2x2
  import pcd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_row_end,
  output logic                 out_frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned XW = (CW > IW_W) ? CW + 1 : IW_W + 1;

  logic [PIX_W-1:0] line_colour_r;
  logic [IW_W-1:0]  image_width_r;
  logic [IH_W-1:0]  image_height_r;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             left_r, left_nxt;

  logic             clr_r;
  logic [CW-1:0]    clr_cnt_r;

  stage_t           s1_r, s1_nxt;
  logic             s1_valid_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_row_end_r;
  logic             out_frame_end_r;

  logic             in_acc, s1_adv, out_free;
  logic [XW-1:0]    lim_w;
  logic [ROW_W-1:0] lim_h;
  logic             last_col, last_row, cur;
  logic             mark_rd;
  logic             ram_we, ram_wdata;
  logic [CW-1:0]    ram_waddr;
  logic             up;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_colour_r  <= '0;
      image_width_r  <= IW_W'(RESET_SIZE);
      image_height_r <= IH_W'(RESET_SIZE);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_COLOUR:  line_colour_r  <= cfg_wdata[PIX_W-1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[IW_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[IH_W-1:0];
        default: ;
      endcase
    end
  end

  // Last column / row positions after clamping
  always_comb begin
    if (image_width_r == '0) begin
      lim_w = '0;
    end else if (XW'(image_width_r) > XW'(MAX_WIDTH)) begin
      lim_w = XW'(MAX_WIDTH - 1);
    end else begin
      lim_w = XW'(image_width_r) - XW'(1);
    end
    if (image_height_r == '0) begin
      lim_h = '0;
    end else if (image_height_r > IH_W'(MAX_HEIGHT)) begin
      lim_h = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      lim_h = ROW_W'(image_height_r - IH_W'(1));
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !clr_r && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  assign last_col = XW'(col_r) >= lim_w;
  assign last_row = row_r >= lim_h;
  assign cur      = (in_pixel_in == line_colour_r);

  always_comb begin
    s1_nxt.pix        = in_pixel_in;
    s1_nxt.horiz      = cur || ((col_r != '0) && left_r);
    s1_nxt.row_pos    = (row_r != '0);
    s1_nxt.last_col   = last_col;
    s1_nxt.last_frame = last_col && last_row;
    if (last_col) begin
      col_nxt  = '0;
      left_nxt = 1'b0;
      row_nxt  = last_row ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt  = col_r + CW'(1);
      left_nxt = cur;
      row_nxt  = row_r;
    end
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= 1'b0;
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
    end
  end

  // Line store clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + CW'(1);
      if (clr_cnt_r == CW'(MAX_WIDTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_r || in_acc;
  assign ram_waddr = clr_r ? clr_cnt_r : col_r;
  assign ram_wdata = clr_r ? 1'b0 : s1_nxt.horiz;

  pcd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (mark_rd)
  );

  // Stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  assign up = s1_r.row_pos && mark_rd;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pixel_r     <= (s1_r.horiz || up) ? line_colour_r : s1_r.pix;
      out_row_end_r   <= s1_r.last_col;
      out_frame_end_r <= s1_r.last_frame;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// File: hdl/pcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the contents before a write at the same edge.
// No dependencies.
module pcd_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
